/* src/fsslc_pkg.sv */
// Shared types and constants for the frame sync / sequence loss counter.
package fsslc_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SYNC_WORD = 2'd0;
   localparam logic [1:0] CSR_MIN_LEN   = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN   = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Register reset values.
   localparam logic [15:0] SYNC_WORD_RST = 16'h55AA;
   localparam logic [15:0] MIN_LEN_RST   = 16'd56;
   localparam logic [15:0] MAX_LEN_RST   = 16'd8192;

   // Header is seven bytes; six are held, the seventh is the incoming byte.
   localparam int         WIN_DEPTH = 6;
   localparam logic [2:0] FILL_FULL = 3'd6;

   localparam int OUT_COUNT_W = 32;
   localparam int RSP_DATA_W  = 120;

   typedef struct packed {
      logic [1:0]  channel;
      logic [15:0] frame_index;
      logic [15:0] payload_len;
   } hdr_type;

   typedef struct packed {
      hdr_type                 hdr;
      logic [15:0]             lost_frames;
      logic [OUT_COUNT_W-1:0]  channel_frames;
      logic [OUT_COUNT_W-1:0]  channel_lost_total;
   } result_type;

endpackage

/* src/frame_sync_sequence_loss_counter_unit.sv */
// Top level of the frame sync deframer with per-channel sequence loss counting.
//
// Usage:
//   req_* : one stream byte per request (req_tdata[7:0]).
//   rsp_* : one result per completed frame: channel, frame index, payload
//           length, frames lost since the channel's previous index, and the
//           channel's saturating frame and loss counters.
//   csr_* : register writes (sync word, min and max payload length), taken
//           on any cycle with csr_wr_en high; write only while idle.
// Throughput: one byte per clock while not stalled. Per-byte work is a compare
//   on a six-byte shift window plus the incoming byte, or a payload down-counter.
// Result path: the edge that accepts a frame's last byte reads the channel
//   RAM, the next one updates the counters and loads the output buffer.
// Channel state (last index, frame and loss counters) lives in a RAM of
//   NUM_CHANNELS entries; per-entry valid flops make a fresh entry read as zero.
// Reset: registers return to their defaults, the window empties, the
//   deframer hunts, channel entries become invalid; req_tready is held low.
// Stall: a two-entry output buffer holds results; req_tready drops only
//   when the buffer plus the result in flight reach two.
module frame_sync_sequence_loss_counter_unit #(
   parameter int NUM_CHANNELS = 3,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: [7:0] data_byte
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   // rsp_tdata: [1:0] channel, [17:2] frame_index, [33:18] payload_len,
   //            [49:34] lost_frames, [81:50] channel_frames,
   //            [113:82] channel_lost_total, [119:114] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [fsslc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [fsslc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fsslc_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import fsslc_pkg::*;

   localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [7:0] NUM_CH_B = 8'(NUM_CHANNELS);

   // configuration
   logic [15:0] sync_word_ff;
   logic [15:0] min_len_ff;
   logic [15:0] max_len_ff;

   // deframer state
   logic [7:0]        window_ff [WIN_DEPTH];
   logic [7:0]        window_in [WIN_DEPTH];
   logic [2:0]        fill_ff, fill_in;
   logic              in_payload_ff, in_payload_in;
   logic [15:0]       remain_ff, remain_in;
   hdr_type           hdr_ff, hdr_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // header decode of window plus the incoming byte
   logic [15:0]       win_word;
   logic [15:0]       win_len;
   logic [7:0]        win_flag;
   logic [15:0]       win_idx;
   logic              hdr_ok;
   hdr_type           win_hdr;
   logic [ADDR_W-1:0] win_addr;

   logic              req_fire;
   logic              upd_valid;
   logic [ADDR_W-1:0] upd_addr;
   hdr_type           upd_hdr;
   logic              res_valid;
   result_type        res;

   // output buffer: head drives rsp, skid catches a second result
   result_type head_ff, skid_ff;
   logic       head_valid_ff, skid_valid_ff;
   logic       rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   // occupancy counts the buffer plus the result in the stats stage
   assign req_tready = !reset &&
                       ((2'(head_valid_ff) + 2'(skid_valid_ff) + 2'(res_valid)) < 2'd2);

   always_comb begin
      win_word = {window_ff[1], window_ff[0]};
      win_len  = {window_ff[3], window_ff[2]};
      win_flag = window_ff[4];
      win_idx  = {req_tdata, window_ff[5]};
      hdr_ok   = (win_word == sync_word_ff) && (win_flag >= 8'd1) &&
                 (win_flag <= NUM_CH_B) && (win_len >= min_len_ff) &&
                 (win_len <= max_len_ff);
      win_hdr.channel     = win_flag[1:0];
      win_hdr.frame_index = win_idx;
      win_hdr.payload_len = win_len;
      win_addr = ADDR_W'(win_flag - 8'd1);
   end

   always_comb begin
      window_in     = window_ff;
      fill_in       = fill_ff;
      in_payload_in = in_payload_ff;
      remain_in     = remain_ff;
      hdr_in        = hdr_ff;
      addr_in       = addr_ff;
      upd_valid     = 1'b0;
      upd_hdr       = hdr_ff;
      upd_addr      = addr_ff;
      if (req_fire) begin
         if (in_payload_ff) begin
            if (remain_ff <= 16'd1) begin
               // last payload byte: finish the held frame
               upd_valid     = 1'b1;
               in_payload_in = 1'b0;
               remain_in     = 16'd0;
               fill_in       = '0;
            end else begin
               remain_in = remain_ff - 16'd1;
            end
         end else begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
               window_in[i] = window_ff[i + 1];
            end
            window_in[WIN_DEPTH-1] = req_tdata;
            if (fill_ff != FILL_FULL) begin
               fill_in = fill_ff + 3'd1;
            end else if (hdr_ok) begin
               fill_in = '0;
               hdr_in  = win_hdr;
               addr_in = win_addr;
               if (win_len == 16'd0) begin
                  // empty payload finishes on the header's last byte
                  upd_valid = 1'b1;
                  upd_hdr   = win_hdr;
                  upd_addr  = win_addr;
               end else begin
                  in_payload_in = 1'b1;
                  remain_in     = win_len;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      hdr_ff    <= hdr_in;
      addr_ff   <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         in_payload_ff <= 1'b0;
         remain_ff     <= '0;
         sync_word_ff  <= SYNC_WORD_RST;
         min_len_ff    <= MIN_LEN_RST;
         max_len_ff    <= MAX_LEN_RST;
      end else begin
         fill_ff       <= fill_in;
         in_payload_ff <= in_payload_in;
         remain_ff     <= remain_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SYNC_WORD: sync_word_ff <= csr_wr_data;
               CSR_MIN_LEN:   min_len_ff   <= csr_wr_data;
               CSR_MAX_LEN:   max_len_ff   <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   fsslc_stats #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .ADDR_W       (ADDR_W)
   ) u_stats (
      .clock     (clock),
      .reset     (reset),
      .upd_valid (upd_valid),
      .upd_addr  (upd_addr),
      .upd_hdr   (upd_hdr),
      .res_valid (res_valid),
      .res       (res)
   );

   // output buffer
   assign rsp_fire   = head_valid_ff && rsp_tready;
   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = {6'd0, head_ff.channel_lost_total, head_ff.channel_frames,
                        head_ff.lost_frames, head_ff.hdr.payload_len,
                        head_ff.hdr.frame_index, head_ff.hdr.channel};

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         priority if (res_valid && (!head_valid_ff || (rsp_fire && !skid_valid_ff))) begin
            head_valid_ff <= 1'b1;
         end else if (res_valid && rsp_fire) begin
            head_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b1;
         end else if (res_valid) begin
            skid_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            head_valid_ff <= skid_valid_ff;
            skid_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (res_valid && (!head_valid_ff || (rsp_fire && !skid_valid_ff))) begin
         head_ff <= res;
      end else if (res_valid && rsp_fire) begin
         head_ff <= skid_ff;
         skid_ff <= res;
      end else if (res_valid) begin
         skid_ff <= res;
      end else if (rsp_fire) begin
         head_ff <= skid_ff;
      end
   end

endmodule

/* src/fsslc_stats.sv */
// Per-channel statistics: read-modify-write of index and saturating counters in a RAM.
module fsslc_stats #(
   parameter int NUM_CHANNELS = 3,
   parameter int COUNT_WIDTH  = 32,
   parameter int ADDR_W       = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    upd_valid,
   input  logic [ADDR_W-1:0]       upd_addr,
   input  fsslc_pkg::hdr_type      upd_hdr,
   output logic                    res_valid,
   output fsslc_pkg::result_type   res
);
   import fsslc_pkg::*;

   localparam int ENTRY_W = 16 + 2 * COUNT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // entry layout: {loss_total, frame_count, prev_index}
   logic [ENTRY_W-1:0]     mem [NUM_CHANNELS];
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic [NUM_CHANNELS-1:0] entry_valid_ff;
   logic [NUM_CHANNELS-1:0] entry_valid_in;
   logic                   s1_valid_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;
   hdr_type                s1_hdr_ff;

   logic                   first;
   logic [15:0]            last_idx;
   logic [COUNT_WIDTH-1:0] cnt_rd;
   logic [COUNT_WIDTH-1:0] loss_rd;
   logic [15:0]            lost;
   logic [COUNT_WIDTH:0]   cnt_sum;
   logic [COUNT_WIDTH:0]   loss_sum;
   logic [COUNT_WIDTH-1:0] cnt_new;
   logic [COUNT_WIDTH-1:0] loss_new;
   logic [ENTRY_W-1:0]     wr_data;

   always_comb begin
      first    = !entry_valid_ff[s1_addr_ff];
      last_idx = first ? 16'd0 : rd_data_ff[15:0];
      cnt_rd   = first ? '0 : rd_data_ff[16 +: COUNT_WIDTH];
      loss_rd  = first ? '0 : rd_data_ff[16 + COUNT_WIDTH +: COUNT_WIDTH];
      lost     = first ? 16'd0 : (s1_hdr_ff.frame_index - last_idx - 16'd1);
      cnt_sum  = {1'b0, cnt_rd} + (COUNT_WIDTH + 1)'(1);
      loss_sum = {1'b0, loss_rd} + (COUNT_WIDTH + 1)'(lost);
      // carry out means the counter hit its ceiling
      cnt_new  = cnt_sum[COUNT_WIDTH]  ? COUNT_MAX : cnt_sum[COUNT_WIDTH-1:0];
      loss_new = loss_sum[COUNT_WIDTH] ? COUNT_MAX : loss_sum[COUNT_WIDTH-1:0];
      wr_data  = {loss_new, cnt_new, s1_hdr_ff.frame_index};

      entry_valid_in = entry_valid_ff;
      if (s1_valid_ff) begin
         entry_valid_in[s1_addr_ff] = 1'b1;
      end

      res_valid              = s1_valid_ff;
      res.hdr                = s1_hdr_ff;
      res.lost_frames        = lost;
      res.channel_frames     = OUT_COUNT_W'(cnt_new);
      res.channel_lost_total = OUT_COUNT_W'(loss_new);
   end

   // Frames finish at least seven bytes apart, so a read never overlaps
   // the write-back of the same entry.
   always_ff @(posedge clock) begin
      if (upd_valid) begin
         rd_data_ff <= mem[upd_addr];
      end
      if (s1_valid_ff) begin
         mem[s1_addr_ff] <= wr_data;
      end
      s1_addr_ff <= upd_addr;
      s1_hdr_ff  <= upd_hdr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         s1_valid_ff    <= upd_valid;
         entry_valid_ff <= entry_valid_in;
      end
   end

endmodule

/* verif/frame_sync_sequence_loss_counter_unit_tb.sv */
// Self-checking testbench for the frame sync deframer and sequence loss counter.
module frame_sync_sequence_loss_counter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsslc_pkg::*;

   localparam int          NUM_CH       = 3;
   localparam int          HEADER_BYTES = 7;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          PRINT_CAP    = 40;

   // Tracks the deframer state and holds the results each accepted request leads to.
   class frame_scoreboard_type;
      logic [15:0] sync_word, min_len, max_len;
      logic [7:0]  window [HEADER_BYTES];
      int          fill;
      bit          in_payload;
      logic [15:0] remaining;
      logic [15:0] held_len, held_idx;
      logic [7:0]  held_flag;
      logic [15:0] last_idx [NUM_CH];
      logic [31:0] frames [NUM_CH];
      logic [31:0] lost_sum [NUM_CH];
      result_type  expected_q [$];
      int          errors;

      function new();
         sync_word  = SYNC_WORD_RST;
         min_len    = MIN_LEN_RST;
         max_len    = MAX_LEN_RST;
         fill       = 0;
         in_payload = 1'b0;
         remaining  = '0;
         held_len   = '0;
         held_idx   = '0;
         held_flag  = '0;
         errors     = 0;
         foreach (window[i]) window[i] = '0;
         for (int c = 0; c < NUM_CH; c++) begin
            last_idx[c] = '0;
            frames[c]   = '0;
            lost_sum[c] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] value);
         case (idx)
            CSR_SYNC_WORD: sync_word = value;
            CSR_MIN_LEN:   min_len   = value;
            CSR_MAX_LEN:   max_len   = value;
            default: ;
         endcase
      endfunction

      function logic [31:0] saturating_sum(logic [31:0] a, logic [31:0] b);
         if (a == COUNT_MAX || b > COUNT_MAX - a) return COUNT_MAX;
         return a + b;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Frame done: update the channel history and queue the result.
      function void close_frame();
         result_type  r;
         int          ch;
         logic [15:0] lost;
         ch   = (int'(held_flag) - 1) % NUM_CH;
         lost = '0;
         if (frames[ch] != 0) begin
            lost        = held_idx - last_idx[ch] - 16'd1;
            lost_sum[ch] = saturating_sum(lost_sum[ch], {16'd0, lost});
         end
         frames[ch]   = saturating_sum(frames[ch], 32'd1);
         last_idx[ch] = held_idx;
         r.hdr.channel         = held_flag[1:0];
         r.hdr.frame_index     = held_idx;
         r.hdr.payload_len     = held_len;
         r.lost_frames         = lost;
         r.channel_frames      = frames[ch];
         r.channel_lost_total  = lost_sum[ch];
         expected_q.push_back(r);
         in_payload = 1'b0;
         remaining  = '0;
         fill       = 0;
      endfunction

      // One accepted stream byte.
      function void note_byte(logic [7:0] b);
         logic [15:0] word, len, idx;
         logic [7:0]  flag;
         if (in_payload) begin
            if (remaining != 0) remaining--;
            if (remaining == 0) close_frame();
            return;
         end
         if (fill >= HEADER_BYTES) fill = HEADER_BYTES - 1;
         window[fill] = b;
         fill++;
         if (fill < HEADER_BYTES) return;
         word = {window[1], window[0]};
         len  = {window[3], window[2]};
         flag = window[4];
         idx  = {window[6], window[5]};
         if (word != sync_word || flag < 8'd1 || flag > NUM_CH ||
             len < min_len || len > max_len) begin
            for (int i = 0; i < HEADER_BYTES - 1; i++) window[i] = window[i+1];
            window[HEADER_BYTES-1] = '0;
            fill = HEADER_BYTES - 1;
            return;
         end
         held_len  = len;
         held_flag = flag;
         held_idx  = idx;
         fill      = 0;
         if (len == 0) begin
            close_frame();
         end else begin
            in_payload = 1'b1;
            remaining  = len;
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
      endtask

      task check_result(logic [RSP_DATA_W-1:0] d);
         result_type e;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result ch=%0d idx=%0d", d[1:0], d[17:2]));
            return;
         end
         e = expected_q.pop_front();
         if (d[1:0] != e.hdr.channel)
            report_mismatch($sformatf("channel %0d, want %0d", d[1:0], e.hdr.channel));
         if (d[17:2] != e.hdr.frame_index)
            report_mismatch($sformatf("frame_index %0d, want %0d", d[17:2],
                                      e.hdr.frame_index));
         if (d[33:18] != e.hdr.payload_len)
            report_mismatch($sformatf("payload_len %0d, want %0d", d[33:18],
                                      e.hdr.payload_len));
         if (d[49:34] != e.lost_frames)
            report_mismatch($sformatf("lost_frames %0d, want %0d", d[49:34], e.lost_frames));
         if (d[81:50] != e.channel_frames)
            report_mismatch($sformatf("channel_frames %0d, want %0d", d[81:50],
                                      e.channel_frames));
         if (d[113:82] != e.channel_lost_total)
            report_mismatch($sformatf("channel_lost_total %0d, want %0d", d[113:82],
                                      e.channel_lost_total));
      endtask
   endclass

   // Receiver back-pressure patterns
   typedef enum int {SINK_OPEN, SINK_BUSY, SINK_CHOKED, SINK_PERIODIC} sink_mode_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata   = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]     rsp_tdata;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index   = '0;
   logic [CSR_DATA_W-1:0]     csr_wr_data = '0;

   frame_scoreboard_type sb = new();

   int            items_sent  = 0;
   int            burst_left  = 0;
   int            cycle_count = 0;
   int            sink_left   = 0;
   sink_mode_type sink_mode   = SINK_OPEN;
   logic [15:0]   gen_last [NUM_CH+1];   // generator's idea of each channel's last index

   frame_sync_sequence_loss_counter_unit #(
      .NUM_CHANNELS(NUM_CH),
      .COUNT_WIDTH (32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: check what was taken at this edge, then pick next tready.
   // Modes switch at random intervals so stalls land on every phase.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_left = $urandom_range(40, 400);
      end else begin
         sink_left--;
      end
      case (sink_mode)
         SINK_OPEN:   rsp_tready <= 1'b1;
         SINK_BUSY:   rsp_tready <= ($urandom_range(0, 3) != 0);
         SINK_CHOKED: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:     rsp_tready <= ((cycle_count % 7) < 3);
      endcase
   end

   // One request. Bursts of random length with random idle gaps; steady
   // requests go back to back.
   task automatic send_byte(input logic [7:0] b, input bit steady = 1'b0);
      int idle;
      if (!steady) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle > 0) begin
               req_tvalid <= 1'b0;
               repeat (idle) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b);
      items_sent++;
   endtask

   // Header bytes little-endian, then optionally a random payload of len bytes.
   task automatic send_frame(input logic [15:0] sync, input logic [15:0] len,
                             input logic [7:0] flag, input logic [15:0] idx,
                             input bit with_payload = 1'b1, input bit steady = 1'b0);
      send_byte(sync[7:0], steady);
      send_byte(sync[15:8], steady);
      send_byte(len[7:0], steady);
      send_byte(len[15:8], steady);
      send_byte(flag, steady);
      send_byte(idx[7:0], steady);
      send_byte(idx[15:8], steady);
      if (with_payload) repeat (len) send_byte(8'($urandom), steady);
   endtask

   // Pause the sender until every queued result is out, then cover latency.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all three registers back to back; only called after a drain.
   task automatic configure(input logic [15:0] sync, input logic [15:0] lo,
                            input logic [15:0] hi);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SYNC_WORD;
      csr_wr_data <= sync;
      @(posedge clock);
      csr_index   <= CSR_MIN_LEN;
      csr_wr_data <= lo;
      @(posedge clock);
      csr_index   <= CSR_MAX_LEN;
      csr_wr_data <= hi;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.write_reg(CSR_SYNC_WORD, sync);
      sb.write_reg(CSR_MIN_LEN, lo);
      sb.write_reg(CSR_MAX_LEN, hi);
   endtask

   // Mostly good frames with random content and index steps; the rest are
   // broken headers and loose bytes. Ends on a good frame so the window is
   // empty before the next register change. Expects hi well below 16'hFF00.
   task automatic random_traffic(input int n_items, input logic [15:0] sync,
                                 input logic [15:0] lo, input logic [15:0] hi);
      int          stop_at;
      int          pick;
      logic [7:0]  flag;
      logic [15:0] idx, len;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         flag = 8'($urandom_range(1, NUM_CH));
         len  = 16'($urandom_range(lo, hi));
         idx  = 16'($urandom);
         if (pick < 70) begin
            case ($urandom_range(0, 9))
               0:       idx = gen_last[flag];                             // repeat
               1, 2:    idx = gen_last[flag] + 16'($urandom_range(2, 6)); // gap
               3:       ;                                                 // jump
               default: idx = gen_last[flag] + 16'd1;                     // in order
            endcase
            gen_last[flag] = idx;
            send_frame(sync, len, flag, idx);
         end else if (pick < 85) begin
            case ($urandom_range(0, 2))
               0: send_frame(sync ^ (16'd1 << $urandom_range(0, 15)), len, flag, idx, 1'b0);
               1: begin
                  flag = ($urandom_range(0, 1) == 0) ? 8'd0
                                                     : 8'($urandom_range(NUM_CH + 1, 255));
                  send_frame(sync, len, flag, idx, 1'b0);
               end
               default: begin
                  if (lo != 0 && $urandom_range(0, 1) == 0)
                     len = 16'($urandom_range(0, lo - 1));
                  else
                     len = hi + 16'd1 + 16'($urandom_range(0, 200));
                  send_frame(sync, len, flag, idx, 1'b0);
               end
            endcase
         end else begin
            // loose bytes, sometimes a lone first sync byte
            repeat ($urandom_range(1, 6))
               send_byte(($urandom_range(0, 3) == 0) ? sync[7:0] : 8'($urandom));
         end
      end
      gen_last[1] = gen_last[1] + 16'd1;
      send_frame(sync, lo, 8'd1, gen_last[1]);
   endtask

   initial begin
      logic [15:0] r_sync, r_lo, r_hi;
      foreach (gen_last[i]) gen_last[i] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset register values: shortest legal frame, lengths just outside.
      send_frame(SYNC_WORD_RST, MIN_LEN_RST, 8'd1, 16'h0000);
      send_frame(SYNC_WORD_RST, MIN_LEN_RST - 16'd1, 8'd2, 16'h0001, 1'b0);
      send_frame(SYNC_WORD_RST, MAX_LEN_RST + 16'd1, 8'd3, 16'h0002, 1'b0);
      drain_results();

      // Directed cases on a short length window.
      configure(16'h55AA, 16'd0, 16'd8);
      send_frame(16'h55AA, 16'd0, 8'd2, 16'hFFFF);        // empty payload, first frame
      send_frame(16'h55AA, 16'd0, 8'd2, 16'h0000);        // index wraps, no loss
      send_frame(16'h55AA, 16'd8, 8'd2, 16'h0000);        // repeated index, max length
      send_frame(16'h55AA, 16'd1, 8'd3, 16'h1234);
      send_frame(16'h55AA, 16'd2, 8'd3, 16'h1230);        // index goes backwards
      send_frame(16'h55AA, 16'd0, 8'd0, 16'h0007, 1'b0);  // flag below range
      send_frame(16'h55AA, 16'd0, 8'd4, 16'h0007, 1'b0);  // flag above range
      send_frame(16'h55AA, 16'd0, 8'hFF, 16'h0007, 1'b0);
      send_frame(16'h55AA, 16'd9, 8'd1, 16'h0007, 1'b0);  // length above max
      send_byte(8'hAA);                                   // false start, window slides
      send_frame(16'h55AA, 16'd3, 8'd1, 16'h0005);
      send_frame(16'h55AA, 16'd5, 8'd1, 16'hFF00);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_frame(16'h55AA, 16'd0, 8'd1, 16'hFF01);
      drain_results();

      // Main random traffic on the default sync word.
      configure(16'h55AA, 16'd0, 16'd12);
      random_traffic(100, 16'h55AA, 16'd0, 16'd12);
      drain_results();

      // Min above max: nothing may ever come out.
      configure(16'h55AA, 16'd10, 16'd9);
      send_frame(16'h55AA, 16'd9, 8'd1, 16'h0100);
      send_frame(16'h55AA, 16'd10, 8'd2, 16'h0200);
      send_frame(16'h55AA, 16'd0, 8'd3, 16'h0300, 1'b0);
      send_frame(16'h55AA, 16'hFFFF, 8'd1, 16'h0400, 1'b0);
      drain_results();

      // Random sync word and length window.
      r_sync = 16'($urandom);
      r_lo   = 16'($urandom_range(0, 20));
      r_hi   = r_lo + 16'($urandom_range(0, 16));
      configure(r_sync, r_lo, r_hi);
      random_traffic(50, r_sync, r_lo, r_hi);
      drain_results();

      // All-zero sync word, widest length window; clean frames only.
      configure(16'h0000, 16'h0000, 16'hFFFF);
      send_frame(16'h0000, 16'd0, 8'd1, 16'h0007);
      send_frame(16'h0000, 16'd3, 8'd2, 16'h8000);
      send_frame(16'h0000, 16'd0, 8'd3, 16'hFFFF);
      send_frame(16'h0000, 16'd1, 8'd1, 16'h0009);
      drain_results();

      // All-ones sync word: lengths at the top of the range are checked
      //   against the bounds, then a frame with payload; the first and last go back to back.
      configure(16'hFFFF, 16'hFFFE, 16'hFFFE);
      send_frame(16'hFFFF, 16'hFFFF, 8'd2, 16'hFFFF, 1'b0, 1'b1);  // length above max
      send_frame(16'hFFFF, 16'hFFFD, 8'd1, 16'h0000, 1'b0);        // length below min
      drain_results();
      configure(16'hFFFF, 16'h0000, 16'hFFFF);
      send_frame(16'hFFFF, 16'd24, 8'd2, 16'hFFFF, 1'b1, 1'b1);
      drain_results();

      // Back to the default sync word for a last stretch.
      configure(SYNC_WORD_RST, 16'd0, 16'd20);
      random_traffic(50, SYNC_WORD_RST, 16'd0, 16'd20);

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
